/* sv/tal_pkg.sv */
// Shared types, constants and helper functions for the lowest-common-ancestor lifting unit.
package tal_pkg;

    localparam int MAX_NODES   = 1024;
    localparam int NODE_W      = 10;
    localparam int CNT_W       = 11;
    localparam int DEPTH_W     = 11;
    localparam int LIFT_LEVELS = 10;
    localparam int LVL_W       = 4;
    localparam int TAB_AW      = LVL_W + NODE_W;
    localparam int TAB_DEPTH   = LIFT_LEVELS * MAX_NODES;
    localparam int OP_W        = 2;

    // Stream payload layout
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 16;
    localparam int FA_LSB      = 0;
    localparam int FB_LSB      = NODE_W;
    localparam int FD_LSB      = 2 * NODE_W;

    // Operation codes
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_BUILD = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

    // Lift table read address select
    localparam logic [1:0] TRD_V = 2'd0;  // {k, v}
    localparam logic [1:0] TRD_P = 2'd1;  // {k, table read data}
    localparam logic [1:0] TRD_X = 2'd2;  // {k, x}
    localparam logic [1:0] TRD_Y = 2'd3;  // {k, y}

    typedef struct packed {
        logic       take;       // latch request fields
        logic       load_wr;    // write parent and depth of node x
        logic       dep_rd_b;   // depth read at y instead of x
        logic [1:0] tab_rd;     // lift table read address select
        logic       bld_wr;     // write level k+1 of node v
        logic       cap_dx;     // hold depth of x
        logic       order;      // swap so x is deeper, form depth difference
        logic       lift_x;     // x takes table read data
        logic       cap_p;      // hold table read data as px
        logic       step_pair;  // move x and y up when ancestors differ
        logic       k_clr;
        logic       k_inc;
        logic       k_top;
        logic       k_dec;
        logic       v_clr;
        logic       v_inc;
        logic       res_x;      // push x into the result register
    } t_dp_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            a_ok;
        logic            b_ok;
        logic            lv_one;
        logic            k_last_bld;
        logic            k_last_up;
        logic            k_zero;
        logic            v_last;
        logic            diff_bit;
        logic            xy_eq;
        logic            out_busy;
    } t_dp_sts;

    // Clamp a node count to [1, MAX_NODES]
    function automatic logic [CNT_W-1:0] f_clamp(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        r = v;
        if (v == '0) r = CNT_W'(1);
        if (v > CNT_W'(MAX_NODES)) r = CNT_W'(MAX_NODES);
        return r;
    endfunction

    // floor(log2(n)) + 1, capped at LIFT_LEVELS
    function automatic logic [LVL_W-1:0] f_levels(input logic [CNT_W-1:0] n);
        logic [LVL_W:0] lv;
        lv = (LVL_W+1)'(1);
        for (int i = 1; i < CNT_W; i++) begin
            if (n[i]) lv = (LVL_W+1)'(i + 1);
        end
        if (lv > (LVL_W+1)'(LIFT_LEVELS)) lv = (LVL_W+1)'(LIFT_LEVELS);
        return lv[LVL_W-1:0];
    endfunction

endpackage

/* sv/tal_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module tal_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/tal_dp.sv */
// Datapath: request registers, lift table and depth memories, counters, result register.
module tal_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [tal_pkg::OP_W-1:0]      i_op,
    input  logic [tal_pkg::IN_TDATA_W-1:0] i_data,
    input  logic                          i_cfg_we,
    input  logic [tal_pkg::CNT_W-1:0]     i_cfg_data,
    input  tal_pkg::t_dp_cmd              i_cmd,
    output tal_pkg::t_dp_sts              o_sts,
    input  logic                          i_m_ready,
    output logic                          o_m_valid,
    output logic [tal_pkg::NODE_W-1:0]    o_m_data
);

    logic [tal_pkg::OP_W-1:0]    r_op;
    logic [tal_pkg::NODE_W-1:0]  r_x;
    logic [tal_pkg::NODE_W-1:0]  r_y;
    logic [tal_pkg::DEPTH_W-1:0] r_d;
    logic [tal_pkg::DEPTH_W-1:0] r_dx;
    logic [tal_pkg::DEPTH_W-1:0] r_diff;
    logic [tal_pkg::NODE_W-1:0]  r_p;
    logic [tal_pkg::LVL_W-1:0]   r_k;
    logic [tal_pkg::NODE_W-1:0]  r_v;
    logic [tal_pkg::CNT_W-1:0]   r_n;
    logic [tal_pkg::LVL_W-1:0]   r_lv;
    logic                        r_out_valid;
    logic [tal_pkg::NODE_W-1:0]  r_res;

    logic                        tab_we;
    logic [tal_pkg::TAB_AW-1:0]  tab_waddr;
    logic [tal_pkg::NODE_W-1:0]  tab_wdata;
    logic [tal_pkg::TAB_AW-1:0]  tab_raddr;
    logic [tal_pkg::NODE_W-1:0]  tab_rdata;
    logic [tal_pkg::NODE_W-1:0]  dep_raddr;
    logic [tal_pkg::DEPTH_W-1:0] dep_rdata;
    logic [tal_pkg::LVL_W-1:0]   k_next;
    logic                        b_ok;

    assign k_next = r_k + tal_pkg::LVL_W'(1);
    assign b_ok   = {1'b0, r_y} < r_n;

    // Node count and level count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n  <= tal_pkg::CNT_W'(tal_pkg::MAX_NODES);
            r_lv <= tal_pkg::f_levels(tal_pkg::CNT_W'(tal_pkg::MAX_NODES));
        end else if (i_cfg_we) begin
            r_n  <= tal_pkg::f_clamp(i_cfg_data);
            r_lv <= tal_pkg::f_levels(tal_pkg::f_clamp(i_cfg_data));
        end
    end

    // Request fields and query working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_op <= i_op;
            r_x  <= i_data[tal_pkg::FA_LSB +: tal_pkg::NODE_W];
            r_y  <= i_data[tal_pkg::FB_LSB +: tal_pkg::NODE_W];
            r_d  <= i_data[tal_pkg::FD_LSB +: tal_pkg::DEPTH_W];
        end
        if (i_cmd.cap_dx) begin
            r_dx <= dep_rdata;
        end
        if (i_cmd.order) begin
            if (r_dx < dep_rdata) begin
                r_x    <= r_y;
                r_y    <= r_x;
                r_diff <= dep_rdata - r_dx;
            end else begin
                r_diff <= r_dx - dep_rdata;
            end
        end
        if (i_cmd.lift_x) begin
            r_x <= tab_rdata;
        end
        if (i_cmd.cap_p) begin
            r_p <= tab_rdata;
        end
        if (i_cmd.step_pair && (r_p != tab_rdata)) begin
            r_x <= r_p;
            r_y <= tab_rdata;
        end
    end

    // Level and node counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= '0;
            r_v <= '0;
        end else begin
            if (i_cmd.k_clr) begin
                r_k <= '0;
            end else if (i_cmd.k_inc) begin
                r_k <= k_next;
            end else if (i_cmd.k_top) begin
                r_k <= r_lv - tal_pkg::LVL_W'(1);
            end else if (i_cmd.k_dec) begin
                r_k <= r_k - tal_pkg::LVL_W'(1);
            end
            if (i_cmd.v_clr) begin
                r_v <= '0;
            end else if (i_cmd.v_inc) begin
                r_v <= r_v + tal_pkg::NODE_W'(1);
            end
        end
    end

    // Lift table read address
    always_comb begin
        unique case (i_cmd.tab_rd)
            tal_pkg::TRD_V: tab_raddr = {r_k, r_v};
            tal_pkg::TRD_P: tab_raddr = {r_k, tab_rdata};
            tal_pkg::TRD_X: tab_raddr = {r_k, r_x};
            tal_pkg::TRD_Y: tab_raddr = {r_k, r_y};
            default:        tab_raddr = {r_k, r_x};
        endcase
    end

    // Lift table write: parent on load, doubled ancestor on build
    assign tab_we    = i_cmd.load_wr | i_cmd.bld_wr;
    assign tab_waddr = i_cmd.bld_wr ? {k_next, r_v} : {tal_pkg::LVL_W'(0), r_x};
    assign tab_wdata = i_cmd.bld_wr ? tab_rdata : (b_ok ? r_y : r_x);
    assign dep_raddr = i_cmd.dep_rd_b ? r_y : r_x;

    tal_ram #(
        .WIDTH (tal_pkg::NODE_W),
        .DEPTH (tal_pkg::TAB_DEPTH)
    ) u_tab (
        .i_clk   (i_clk),
        .i_we    (tab_we),
        .i_waddr (tab_waddr),
        .i_wdata (tab_wdata),
        .i_raddr (tab_raddr),
        .o_rdata (tab_rdata)
    );

    tal_ram #(
        .WIDTH (tal_pkg::DEPTH_W),
        .DEPTH (tal_pkg::MAX_NODES)
    ) u_dep (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load_wr),
        .i_waddr (r_x),
        .i_wdata (r_d),
        .i_raddr (dep_raddr),
        .o_rdata (dep_rdata)
    );

    // Result register, free again once the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.res_x) begin
            r_out_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_x) begin
            r_res <= r_x;
        end
    end

    assign o_m_valid = r_out_valid;
    assign o_m_data  = r_res;

    // Status toward the controller
    always_comb begin
        o_sts.op         = r_op;
        o_sts.a_ok       = {1'b0, r_x} < r_n;
        o_sts.b_ok       = b_ok;
        o_sts.lv_one     = r_lv == tal_pkg::LVL_W'(1);
        o_sts.k_last_bld = ({1'b0, r_k} + (tal_pkg::LVL_W+1)'(2)) == {1'b0, r_lv};
        o_sts.k_last_up  = r_k == (r_lv - tal_pkg::LVL_W'(1));
        o_sts.k_zero     = r_k == '0;
        o_sts.v_last     = {1'b0, r_v} == (r_n - tal_pkg::CNT_W'(1));
        o_sts.diff_bit   = r_diff[r_k];
        o_sts.xy_eq      = r_x == r_y;
        o_sts.out_busy   = r_out_valid & ~i_m_ready;
    end

endmodule

/* sv/tal_ctrl.sv */
// Controller: sequences load, table build and query steps over the datapath.
module tal_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_valid,
    output logic             o_s_ready,
    input  tal_pkg::t_dp_sts i_sts,
    output tal_pkg::t_dp_cmd o_cmd
);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_DISP  = 5'd1;
    localparam logic [4:0] S_BLD_A = 5'd2;
    localparam logic [4:0] S_BLD_B = 5'd3;
    localparam logic [4:0] S_BLD_C = 5'd4;
    localparam logic [4:0] S_QDA   = 5'd5;
    localparam logic [4:0] S_QDB   = 5'd6;
    localparam logic [4:0] S_QDC   = 5'd7;
    localparam logic [4:0] S_QUP   = 5'd8;
    localparam logic [4:0] S_QUPW  = 5'd9;
    localparam logic [4:0] S_QCMP  = 5'd10;
    localparam logic [4:0] S_QDN   = 5'd11;
    localparam logic [4:0] S_QDN1  = 5'd12;
    localparam logic [4:0] S_QDN2  = 5'd13;
    localparam logic [4:0] S_QFIN  = 5'd14;
    localparam logic [4:0] S_QFINW = 5'd15;
    localparam logic [4:0] S_QOUT  = 5'd16;

    logic [4:0] r_state;
    logic [4:0] n_state;

    assign o_s_ready = r_state == S_IDLE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.tab_rd = tal_pkg::TRD_X;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_DISP;
                end
            end
            S_DISP: begin
                n_state = S_IDLE;
                unique case (i_sts.op)
                    tal_pkg::OP_LOAD: begin
                        o_cmd.load_wr = i_sts.a_ok;
                    end
                    tal_pkg::OP_BUILD: begin
                        o_cmd.k_clr = 1'b1;
                        o_cmd.v_clr = 1'b1;
                        if (!i_sts.lv_one) n_state = S_BLD_A;
                    end
                    tal_pkg::OP_QUERY: begin
                        if (i_sts.a_ok && i_sts.b_ok) n_state = S_QDA;
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            // Build: read parent, read its ancestor, write next level
            S_BLD_A: begin
                o_cmd.tab_rd = tal_pkg::TRD_V;
                n_state      = S_BLD_B;
            end
            S_BLD_B: begin
                o_cmd.tab_rd = tal_pkg::TRD_P;
                n_state      = S_BLD_C;
            end
            S_BLD_C: begin
                o_cmd.bld_wr = 1'b1;
                n_state      = S_BLD_A;
                if (i_sts.v_last) begin
                    o_cmd.v_clr = 1'b1;
                    if (i_sts.k_last_bld) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.k_inc = 1'b1;
                    end
                end else begin
                    o_cmd.v_inc = 1'b1;
                end
            end
            // Query: fetch both depths and order the pair
            S_QDA: begin
                n_state = S_QDB;
            end
            S_QDB: begin
                o_cmd.cap_dx   = 1'b1;
                o_cmd.dep_rd_b = 1'b1;
                n_state        = S_QDC;
            end
            S_QDC: begin
                o_cmd.order = 1'b1;
                o_cmd.k_clr = 1'b1;
                n_state     = S_QUP;
            end
            // Lift the deeper node by the depth difference
            S_QUP: begin
                if (i_sts.diff_bit) begin
                    n_state = S_QUPW;
                end else if (i_sts.k_last_up) begin
                    n_state = S_QCMP;
                end else begin
                    o_cmd.k_inc = 1'b1;
                end
            end
            S_QUPW: begin
                o_cmd.lift_x = 1'b1;
                if (i_sts.k_last_up) begin
                    n_state = S_QCMP;
                end else begin
                    o_cmd.k_inc = 1'b1;
                    n_state     = S_QUP;
                end
            end
            S_QCMP: begin
                if (i_sts.xy_eq) begin
                    n_state = S_QOUT;
                end else begin
                    o_cmd.k_top = 1'b1;
                    n_state     = S_QDN;
                end
            end
            // Lift both nodes from the top level down
            S_QDN: begin
                n_state = S_QDN1;
            end
            S_QDN1: begin
                o_cmd.cap_p  = 1'b1;
                o_cmd.tab_rd = tal_pkg::TRD_Y;
                n_state      = S_QDN2;
            end
            S_QDN2: begin
                o_cmd.step_pair = 1'b1;
                if (i_sts.k_zero) begin
                    n_state = S_QFIN;
                end else begin
                    o_cmd.k_dec = 1'b1;
                    n_state     = S_QDN;
                end
            end
            // Take the shared parent
            S_QFIN: begin
                n_state = S_QFINW;
            end
            S_QFINW: begin
                o_cmd.lift_x = 1'b1;
                n_state      = S_QOUT;
            end
            S_QOUT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.res_x = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // A result never overwrites one the receiver has not taken
    a_res_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.res_x |-> !i_sts.out_busy)
        else $error("result pushed into a busy result register");

    // Load and build never share the table write port
    a_one_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.load_wr && o_cmd.bld_wr))
        else $error("load and build write the table together");

    // An accepted request is decoded in the next cycle
    a_take_disp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.take |=> (r_state == S_DISP))
        else $error("accepted request not decoded");

    // A build only starts when there is a level above the parents
    a_build_lv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BLD_A) |-> !i_sts.lv_one)
        else $error("build running with a single level");

endmodule

/* sv/tree_ancestor_query_lifting_unit.sv */
// Top level of the lowest-common-ancestor unit by binary lifting.
// Usage:
//   Requests enter on the s_axis channel: tuser carries the operation (load,
//   build, query), tdata carries node_a, node_b and node_depth. Loads store a
//   node's parent and depth; a build fills the doubling table; a query sends
//   one ancestor on m_axis. Out-of-range queries and unused codes return nothing.
//   The node count is written on the cfg channel while the block is idle; it
//   sets the range of valid nodes and the number of lifting levels L.
// Sequencing (one request at a time, set by the single read port of the table):
//   a build makes three table accesses per entry; a query spends one table
//   read per set bit of the depth difference and two table reads per level on
//   the way down.
// Reset: synchronous active-low; node count returns to 1024 (L = 10). The
//   table and depth memories keep no reset value and must be loaded and built.
// Back-pressure: the result sits in an output register; the next request is
//   accepted while it waits, and a further result stalls until it is taken.
module tree_ancestor_query_lifting_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // tdata fields from bit 0: node_a[9:0], node_b[19:10], node_depth[30:20]
    input  logic [tal_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    // tuser fields from bit 0: operation[1:0]
    input  logic [tal_pkg::OP_W-1:0]       s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // tdata fields from bit 0: ancestor[9:0]
    output logic [tal_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [tal_pkg::CNT_W-1:0]      i_cfg_data
);

    tal_pkg::t_dp_cmd               cmd;
    tal_pkg::t_dp_sts               sts;
    logic [tal_pkg::NODE_W-1:0]     res;

    assign o_cfg_ready  = 1'b1;
    assign m_axis_tdata = {{(tal_pkg::OUT_TDATA_W - tal_pkg::NODE_W){1'b0}}, res};

    tal_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    tal_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op       (s_axis_tuser),
        .i_data     (s_axis_tdata),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_m_ready  (m_axis_tready),
        .o_m_valid  (m_axis_tvalid),
        .o_m_data   (res)
    );

endmodule

/* tb/tb_tree_ancestor_query_lifting_unit.sv */
// Self-checking testbench for the binary-lifting lowest-common-ancestor unit.
`timescale 1ns / 100ps

module tb_tree_ancestor_query_lifting_unit;

    localparam logic [tal_pkg::OP_W-1:0] OP_SPARE = 2'd3;
    localparam int RUN_LIMIT = 3_000_000;
    localparam int BIG_HOLD  = 400;
    localparam int WIDE_TREE = 128;

    logic                            i_clk         = 1'b0;
    logic                            i_rst_n       = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    wire                             s_axis_tready;
    // tdata fields from bit 0: node_a[9:0], node_b[19:10], node_depth[30:20]
    logic [tal_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    // tuser fields from bit 0: operation[1:0]
    logic [tal_pkg::OP_W-1:0]        s_axis_tuser  = '0;
    wire                             m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    // tdata fields from bit 0: ancestor[9:0]
    wire [tal_pkg::OUT_TDATA_W-1:0]  m_axis_tdata;
    logic                            i_cfg_valid   = 1'b0;
    wire                             o_cfg_ready;
    logic [tal_pkg::CNT_W-1:0]       i_cfg_data    = '0;

    // flow-control knobs
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int hold_left      = 0;

    int err_cnt    = 0;
    int req_cnt    = 0;
    int answer_cnt = 0;
    int cycle_cnt  = 0;
    int cur_n      = tal_pkg::MAX_NODES;

    // predictor state: node count register, ancestor table, depths
    logic [tal_pkg::CNT_W-1:0]   count_reg = tal_pkg::CNT_W'(tal_pkg::MAX_NODES);
    logic [tal_pkg::NODE_W-1:0]  lift_anc [tal_pkg::LIFT_LEVELS][tal_pkg::MAX_NODES];
    logic [tal_pkg::DEPTH_W-1:0] node_depth_mem [tal_pkg::MAX_NODES];
    logic [tal_pkg::NODE_W-1:0]  ancestor_q [$];
    logic [tal_pkg::NODE_W-1:0]  ans_want;

    // stimulus-side picture of the loaded tree
    int tree_par [tal_pkg::MAX_NODES];
    int tree_dep [tal_pkg::MAX_NODES];

    tree_ancestor_query_lifting_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Clamp the count register into the usable node range
    function automatic int eff_node_count();
        int n;
        n = count_reg;
        if (n < 1) n = 1;
        if (n > tal_pkg::MAX_NODES) n = tal_pkg::MAX_NODES;
        return n;
    endfunction

    function automatic int levels_for(input int n);
        int lv;
        int m;
        lv = 1;
        m = n;
        while (m > 1) begin
            m = m >> 1;
            lv++;
        end
        if (lv > tal_pkg::LIFT_LEVELS) lv = tal_pkg::LIFT_LEVELS;
        return lv;
    endfunction

    // Apply one request to the predictor; returns 1 when an answer is due
    function automatic bit apply_request(input logic [tal_pkg::OP_W-1:0] op,
                                         input logic [tal_pkg::NODE_W-1:0] a,
                                         input logic [tal_pkg::NODE_W-1:0] b,
                                         input logic [tal_pkg::DEPTH_W-1:0] d,
                                         output logic [tal_pkg::NODE_W-1:0] anc);
        int n;
        int lv;
        logic [tal_pkg::NODE_W-1:0]  x, y, px, py;
        logic [tal_pkg::DEPTH_W-1:0] diff;
        n = eff_node_count();
        lv = levels_for(n);
        anc = '0;
        case (op)
            tal_pkg::OP_LOAD: begin
                if (a < n) begin
                    lift_anc[0][a] = (b < n) ? b : a;
                    node_depth_mem[a] = d;
                end
                return 1'b0;
            end
            tal_pkg::OP_BUILD: begin
                for (int k = 0; k + 1 < lv; k++) begin
                    for (int v = 0; v < n; v++) begin
                        lift_anc[k+1][v] = lift_anc[k][lift_anc[k][v]];
                    end
                end
                return 1'b0;
            end
            tal_pkg::OP_QUERY: begin
                if (a >= n || b >= n) return 1'b0;
                // make x the deeper node
                if (node_depth_mem[a] < node_depth_mem[b]) begin
                    x = b;
                    y = a;
                end else begin
                    x = a;
                    y = b;
                end
                diff = node_depth_mem[x] - node_depth_mem[y];
                for (int k = 0; k < lv; k++) begin
                    if (diff[k]) x = lift_anc[k][x];
                end
                if (x == y) begin
                    anc = x;
                    return 1'b1;
                end
                // climb both from the top level while ancestors differ
                for (int k = lv - 1; k >= 0; k--) begin
                    px = lift_anc[k][x];
                    py = lift_anc[k][y];
                    if (px != py) begin
                        x = px;
                        y = py;
                    end
                end
                anc = lift_anc[0][x];
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic int drain_cycles();
        int n;
        int lv;
        n = eff_node_count();
        lv = levels_for(n);
        return 3 * n * (lv - 1) + 5 * lv + 40;
    endfunction

    function automatic int pick_ancestor(input int a);
        int x;
        x = a;
        repeat ($urandom_range(0, 15)) x = tree_par[x];
        return x;
    endfunction

    // Offer one request, hold it until accepted, then update the predictor
    task automatic send_req(input logic [tal_pkg::OP_W-1:0] op,
                            input logic [tal_pkg::NODE_W-1:0] a,
                            input logic [tal_pkg::NODE_W-1:0] b,
                            input logic [tal_pkg::DEPTH_W-1:0] d);
        logic [tal_pkg::NODE_W-1:0] anc;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {1'b0, d, b, a};
        do @(posedge i_clk); while (!s_axis_tready);
        req_cnt++;
        if (apply_request(op, a, b, d, anc)) ancestor_q = {ancestor_q, anc};
        @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [tal_pkg::CNT_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        count_reg = val;
        cur_n = eff_node_count();
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Drop the request line and let every answer and any build finish
    task automatic quiesce();
        s_axis_tvalid <= 1'b0;
        while (ancestor_q.size() != 0) @(negedge i_clk);
        repeat (drain_cycles()) @(negedge i_clk);
    endtask

    // Load a random well-formed tree of n nodes, chain-like or bushy
    task automatic load_tree(input int n);
        int perm [tal_pkg::MAX_NODES];
        int span, j, t, p;
        for (int i = 0; i < n; i++) perm[i] = i;
        for (int i = n - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = perm[i];
            perm[i] = perm[j];
            perm[j] = t;
        end
        span = ($urandom_range(0, 1) == 0) ? 2 : n;
        tree_par[perm[0]] = perm[0];
        tree_dep[perm[0]] = 1;
        for (int i = 1; i < n; i++) begin
            p = perm[$urandom_range((i > span) ? i - span : 0, i - 1)];
            tree_par[perm[i]] = p;
            tree_dep[perm[i]] = tree_dep[p] + 1;
        end
        for (int v = 0; v < n; v++) begin
            send_req(tal_pkg::OP_LOAD, tal_pkg::NODE_W'(v), tal_pkg::NODE_W'(tree_par[v]),
                     tal_pkg::DEPTH_W'(tree_dep[v]));
        end
    endtask

    // Mostly queries on the loaded tree, with reloads, rebuilds and noise
    task automatic run_mix(input int cnt);
        int done, r, a, b, d, p, t;
        done = 0;
        while (done < cnt) begin
            r = $urandom_range(0, 99);
            a = $urandom_range(0, cur_n - 1);
            if (r < 62 || r >= 94) begin
                case ($urandom_range(0, 4))
                    0, 1: b = pick_ancestor(a);
                    2: b = a;
                    default: b = $urandom_range(0, cur_n - 1);
                endcase
                if ($urandom_range(0, 1) == 1) begin
                    t = a;
                    a = b;
                    b = t;
                end
                send_req(tal_pkg::OP_QUERY, tal_pkg::NODE_W'(a), tal_pkg::NODE_W'(b),
                         tal_pkg::DEPTH_W'($urandom_range(0, 2047)));
                done++;
            end else if (r < 70 && cur_n < tal_pkg::MAX_NODES) begin
                // one node outside the count
                b = $urandom_range(cur_n, tal_pkg::MAX_NODES - 1);
                if ($urandom_range(0, 1) == 1)
                    send_req(tal_pkg::OP_QUERY, tal_pkg::NODE_W'(a), tal_pkg::NODE_W'(b), '0);
                else
                    send_req(tal_pkg::OP_QUERY, tal_pkg::NODE_W'(b), tal_pkg::NODE_W'(a), '0);
            end else if (r < 78) begin
                // reload a node, sometimes with a foreign parent or a bogus depth
                b = ($urandom_range(0, 4) == 0) ? $urandom_range(0, tal_pkg::MAX_NODES - 1)
                                                : $urandom_range(0, cur_n - 1);
                p = (b < cur_n) ? b : a;
                d = ($urandom_range(0, 9) < 7) ? ((tree_dep[p] + 1) & 'h7ff)
                                               : $urandom_range(0, 2047);
                tree_par[a] = p;
                tree_dep[a] = d;
                send_req(tal_pkg::OP_LOAD, tal_pkg::NODE_W'(a), tal_pkg::NODE_W'(b),
                         tal_pkg::DEPTH_W'(d));
                done++;
            end else if (r < 83) begin
                send_req(tal_pkg::OP_BUILD, tal_pkg::NODE_W'($urandom_range(0, 1023)),
                         tal_pkg::NODE_W'($urandom_range(0, 1023)),
                         tal_pkg::DEPTH_W'($urandom_range(0, 2047)));
                done++;
            end else if (r < 89 || cur_n == tal_pkg::MAX_NODES) begin
                send_req(OP_SPARE, tal_pkg::NODE_W'($urandom_range(0, 1023)),
                         tal_pkg::NODE_W'($urandom_range(0, 1023)),
                         tal_pkg::DEPTH_W'($urandom_range(0, 2047)));
            end else begin
                send_req(tal_pkg::OP_LOAD,
                         tal_pkg::NODE_W'($urandom_range(cur_n, tal_pkg::MAX_NODES - 1)),
                         tal_pkg::NODE_W'($urandom_range(0, 1023)),
                         tal_pkg::DEPTH_W'($urandom_range(0, 2047)));
            end
        end
    endtask

    // Single-node tree, ignored load, unused code, count written as zero
    task automatic test_lone_node();
        cfg_write(tal_pkg::CNT_W'(1));
        send_req(tal_pkg::OP_LOAD, 10'd0, 10'd0, 11'd1);
        send_req(tal_pkg::OP_LOAD, 10'd1, 10'd0, 11'd2);
        send_req(tal_pkg::OP_BUILD, 10'd0, 10'd0, 11'd0);
        send_req(tal_pkg::OP_QUERY, 10'd0, 10'd0, 11'd0);
        send_req(tal_pkg::OP_QUERY, 10'd0, 10'd1, 11'd0);
        send_req(tal_pkg::OP_QUERY, 10'd1023, 10'd0, 11'd0);
        send_req(OP_SPARE, 10'd1023, 10'd1023, 11'd2047);
        quiesce();
        cfg_write(tal_pkg::CNT_W'(0));
        send_req(tal_pkg::OP_LOAD, 10'd1023, 10'd1023, 11'd2047);
        send_req(tal_pkg::OP_QUERY, 10'd0, 10'd0, 11'd2047);
    endtask

    // Hand-built tree: siblings, ancestor pairs, second root, odd depths
    task automatic test_small_tree();
        quiesce();
        cfg_write(tal_pkg::CNT_W'(8));
        send_req(tal_pkg::OP_LOAD, 10'd0, 10'd0, 11'd1);
        send_req(tal_pkg::OP_LOAD, 10'd1, 10'd0, 11'd2);
        send_req(tal_pkg::OP_LOAD, 10'd2, 10'd0, 11'd2);
        send_req(tal_pkg::OP_LOAD, 10'd3, 10'd1, 11'd3);
        send_req(tal_pkg::OP_LOAD, 10'd4, 10'd1, 11'd3);
        send_req(tal_pkg::OP_LOAD, 10'd5, 10'd3, 11'd4);
        send_req(tal_pkg::OP_LOAD, 10'd6, 10'd5, 11'd5);
        // parent outside the count: node turns into a root
        send_req(tal_pkg::OP_LOAD, 10'd7, 10'd1023, 11'd1);
        send_req(tal_pkg::OP_BUILD, 10'd0, 10'd0, 11'd0);
        send_req(tal_pkg::OP_QUERY, 10'd6, 10'd4, 11'd0);
        send_req(tal_pkg::OP_QUERY, 10'd4, 10'd6, 11'd0);
        send_req(tal_pkg::OP_QUERY, 10'd6, 10'd1, 11'd0);
        send_req(tal_pkg::OP_QUERY, 10'd1, 10'd6, 11'd0);
        send_req(tal_pkg::OP_QUERY, 10'd2, 10'd6, 11'd0);
        send_req(tal_pkg::OP_QUERY, 10'd5, 10'd5, 11'd0);
        send_req(tal_pkg::OP_QUERY, 10'd7, 10'd0, 11'd0);
        send_req(tal_pkg::OP_QUERY, 10'd0, 10'd1023, 11'd0);
        // depths outside any sane range, no rebuild
        send_req(tal_pkg::OP_LOAD, 10'd7, 10'd7, 11'd2047);
        send_req(tal_pkg::OP_LOAD, 10'd2, 10'd0, 11'd0);
        send_req(tal_pkg::OP_QUERY, 10'd7, 10'd6, 11'd0);
        send_req(tal_pkg::OP_QUERY, 10'd2, 10'd6, 11'd0);
    endtask

    // Shrink the count after a build; table contents must survive
    task automatic test_count_change();
        quiesce();
        cfg_write(tal_pkg::CNT_W'(16));
        load_tree(16);
        send_req(tal_pkg::OP_BUILD, 10'd0, 10'd0, 11'd0);
        repeat (4) send_req(tal_pkg::OP_QUERY, tal_pkg::NODE_W'($urandom_range(0, 15)),
                            tal_pkg::NODE_W'($urandom_range(0, 15)), '0);
        quiesce();
        cfg_write(tal_pkg::CNT_W'(8));
        repeat (8) send_req(tal_pkg::OP_QUERY, tal_pkg::NODE_W'($urandom_range(0, 15)),
                            tal_pkg::NODE_W'($urandom_range(0, 15)), '0);
        send_req(tal_pkg::OP_BUILD, 10'd0, 10'd0, 11'd0);
        repeat (6) send_req(tal_pkg::OP_QUERY, tal_pkg::NODE_W'($urandom_range(0, 15)),
                            tal_pkg::NODE_W'($urandom_range(0, 15)), '0);
    endtask

    // Random trees under four flow-control mixes
    task automatic test_random_traffic();
        int sizes [8] = '{2, 0, 64, 0, 32, 0, 48, 0};
        int src_mix [4] = '{0, 73, 0, 6};
        int sink_mix [4] = '{0, 0, 73, 6};
        int n;
        for (int m = 0; m < 4; m++) begin
            for (int h = 0; h < 2; h++) begin
                n = sizes[2*m + h];
                if (n == 0) n = $urandom_range(3, 20);
                quiesce();
                src_idle_pct = src_mix[m];
                sink_stall_pct = sink_mix[m];
                cfg_write(tal_pkg::CNT_W'(n));
                load_tree(n);
                send_req(tal_pkg::OP_BUILD, 10'd0, 10'd0, 11'd0);
                run_mix(16);
            end
        end
    endtask

    // Keep the result side blocked while queries keep coming
    task automatic test_output_backpressure();
        quiesce();
        src_idle_pct = 0;
        sink_stall_pct = 0;
        @(posedge i_clk);
        hold_left = BIG_HOLD;
        @(negedge i_clk);
        repeat (16) send_req(tal_pkg::OP_QUERY, tal_pkg::NODE_W'($urandom_range(0, cur_n - 1)),
                             tal_pkg::NODE_W'($urandom_range(0, cur_n - 1)), '0);
    endtask

    // Widest tree of the run; then count written above the range
    task automatic test_wide_tree();
        quiesce();
        src_idle_pct = 0;
        sink_stall_pct = 0;
        cfg_write(tal_pkg::CNT_W'(WIDE_TREE));
        load_tree(WIDE_TREE);
        send_req(tal_pkg::OP_BUILD, 10'd0, 10'd0, 11'd0);
        send_req(tal_pkg::OP_QUERY, tal_pkg::NODE_W'(WIDE_TREE - 1),
                 tal_pkg::NODE_W'(pick_ancestor(WIDE_TREE - 1)), 11'd0);
        send_req(tal_pkg::OP_QUERY, tal_pkg::NODE_W'(WIDE_TREE - 1), 10'd0, 11'd0);
        send_req(tal_pkg::OP_QUERY, 10'd0, tal_pkg::NODE_W'(WIDE_TREE - 1), 11'd2047);
        send_req(tal_pkg::OP_QUERY, tal_pkg::NODE_W'(WIDE_TREE - 1),
                 tal_pkg::NODE_W'(WIDE_TREE - 1), 11'd0);
        run_mix(20);
        quiesce();
        src_idle_pct = 6;
        sink_stall_pct = 6;
        // count clamps to the full range; self queries touch only depths
        cfg_write(tal_pkg::CNT_W'(2047));
        send_req(tal_pkg::OP_LOAD, 10'd1023, 10'd1023, 11'd1);
        send_req(tal_pkg::OP_QUERY, 10'd1023, 10'd1023, 11'd0);
        send_req(tal_pkg::OP_QUERY, 10'd5, 10'd5, 11'd0);
    endtask

    // Result side: long hold when asked, random stalls otherwise
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // Compare each answer with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (ancestor_q.size() == 0) begin
                $error("unexpected result: ancestor %0d", m_axis_tdata[tal_pkg::NODE_W-1:0]);
                err_cnt++;
            end else begin
                ans_want = ancestor_q.pop_front();
                answer_cnt++;
                if (m_axis_tdata[tal_pkg::NODE_W-1:0] !== ans_want) begin
                    $error("ancestor: expected %0d, got %0d", ans_want,
                           m_axis_tdata[tal_pkg::NODE_W-1:0]);
                    err_cnt++;
                end
            end
        end
    end

    // Watchdog
    initial begin
        while (cycle_cnt < RUN_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("timeout after %0d cycles", cycle_cnt);
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_lone_node();
        test_small_tree();
        test_count_change();
        test_random_traffic();
        test_output_backpressure();
        test_wide_tree();
        quiesce();
        if (ancestor_q.size() != 0) begin
            $error("%0d predicted answers never arrived", ancestor_q.size());
            err_cnt++;
        end
        $display("Sent %0d requests and checked %0d answers across node counts 1 to 1024,",
                 req_cnt, answer_cnt);
        $display("with idle and stall mixes, count changes and a long output hold.");
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

/* filelist.f */
sv/tal_pkg.sv
sv/tal_ram.sv
sv/tal_dp.sv
sv/tal_ctrl.sv
sv/tree_ancestor_query_lifting_unit.sv
tb/tb_tree_ancestor_query_lifting_unit.sv
